/* rtl/core/lalg_pkg.sv */
`default_nettype none
package lalg_pkg;

    // default sequence capacity
    localparam int MAX_LEN_DEF = 32;

    // most pairs one run gives out
    localparam int RESULT_CAP = 64;

    // aligned symbol for a gap
    localparam logic [7:0] GAP_SYM = 8'd45;

    // input actions
    localparam logic [1:0] ACT_LOAD_TOP  = 2'd0;
    localparam logic [1:0] ACT_LOAD_LEFT = 2'd1;
    localparam logic [1:0] ACT_RUN       = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    // register reset values
    localparam logic [3:0] MATCH_RST    = 4'd2;
    localparam logic [4:0] MISMATCH_RST = 5'h1f;
    localparam logic [4:0] GAP_RST      = 5'h1f;

endpackage
`default_nettype wire

/* rtl/core/lalg_ram.sv */
`default_nettype none
module lalg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/lalg_pe.sv */
`default_nettype none
module lalg_pe #(
    parameter int SW = 9
) (
    input  wire logic [SW-1:0]        i_diag,
    input  wire logic [SW-1:0]        i_up,
    input  wire logic [SW-1:0]        i_left,
    input  wire logic                 i_sym_eq,
    input  wire logic [3:0]           i_match,
    input  wire logic signed [4:0]    i_mismatch,
    input  wire logic signed [4:0]    i_gap,
    output logic signed [SW+1:0]      o_diag_sum,
    output logic signed [SW+1:0]      o_left_sum,
    output logic [SW-1:0]             o_val
);

    localparam int SSW = SW + 2;

    logic signed [SSW-1:0] gain;
    logic signed [SSW-1:0] gap_ext;
    logic signed [SSW-1:0] up_sum;
    logic signed [SSW-1:0] best;

    // candidate scores from the three neighbors
    always_comb begin
        gain = i_sym_eq ? $signed({{(SSW-4){1'b0}}, i_match})
                        : $signed({{(SSW-5){i_mismatch[4]}}, i_mismatch});
        gap_ext    = $signed({{(SSW-5){i_gap[4]}}, i_gap});
        o_diag_sum = $signed({2'b00, i_diag}) + gain;
        o_left_sum = $signed({2'b00, i_left}) + gap_ext;
        up_sum     = $signed({2'b00, i_up}) + gap_ext;
    end

    // floor at zero and take the greatest
    always_comb begin
        best = '0;
        if (o_diag_sum > best) best = o_diag_sum;
        if (up_sum > best) best = up_sum;
        if (o_left_sum > best) best = o_left_sum;
        o_val = best[SW-1:0];
    end

endmodule
`default_nettype wire

/* rtl/core/local_alignment_linear_gap.sv */
// load word: accepted without stall while idle, next word may follow at once
// run word: each matrix cell takes a score memory read of the upper cell (S_FRD),
//   then compute and write back (S_FCMP); S_FDONE starts the traceback; each
//   traceback pair steps through S_TCHK, S_THD, S_TDD, S_TLD and S_TPUT, which
//   waits on the output stall; S_TFIN ends; one score memory port sets the pace
// reset: synchronous active low, clears lengths, registers to defaults;
//   sequence and score memories are not cleared and need no clearing pass
`default_nettype none
module local_alignment_linear_gap #(
    parameter int MAX_LEN = lalg_pkg::MAX_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_symbol,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_pair_valid,
    output logic [7:0]       o_top_out,
    output logic [7:0]       o_left_out,
    output logic             o_last,
    output logic [8:0]       o_best_score,
    output logic [5:0]       o_end_row,
    output logic [5:0]       o_end_col,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);

    localparam int SW   = $clog2(MAX_LEN * 15 + 1);
    localparam int RC_W = $clog2(MAX_LEN + 1);
    localparam int SAW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int MAW  = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;
    localparam int NW   = $clog2(lalg_pkg::RESULT_CAP + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FRD   = 10'b0000000010,
        S_FCMP  = 10'b0000000100,
        S_FDONE = 10'b0000001000,
        S_TCHK  = 10'b0000010000,
        S_THD   = 10'b0000100000,
        S_TDD   = 10'b0001000000,
        S_TLD   = 10'b0010000000,
        S_TPUT  = 10'b0100000000,
        S_TFIN  = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [RC_W-1:0] r_tcnt, r_lcnt, r_r, r_c, r_br, r_bc;
    logic [SW-1:0] r_diag, r_left, r_best, r_here;
    logic [NW-1:0] r_n;
    logic r_pend_v;
    logic [7:0] r_pend_top, r_pend_left, r_nxt_top, r_nxt_left;
    logic [3:0] r_match;
    logic [4:0] r_mismatch, r_gap;

    logic [RC_W-1:0] c_m1, r_m1;
    logic [7:0] top_rd, left_rd;
    logic [SW-1:0] score_rd, up_now, left_now, pe_left, pe_up, pe_val;
    logic signed [SW+1:0] pe_dsum, pe_lsum, here_ext;
    logic [MAW-1:0] score_raddr;
    logic score_we, load_top, load_left, out_free, emit;
    logic [SW+8:0] best_ext;
    logic [RC_W+5:0] br_ext, bc_ext;

    // flat index of a 1-based inner cell
    function automatic logic [MAW-1:0] f_addr(input logic [RC_W-1:0] rr,
                                              input logic [RC_W-1:0] cc);
        logic [RC_W-1:0] r1;
        logic [RC_W-1:0] c1;
        r1 = rr - 1'b1;
        c1 = cc - 1'b1;
        return MAW'(int'(r1) * MAX_LEN + int'(c1));
    endfunction

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign c_m1 = r_c - 1'b1;
    assign r_m1 = r_r - 1'b1;
    assign load_top  = i_valid && (r_state == S_IDLE) && (i_action == lalg_pkg::ACT_LOAD_TOP)
                       && (r_tcnt < RC_W'(MAX_LEN));
    assign load_left = i_valid && (r_state == S_IDLE) && (i_action == lalg_pkg::ACT_LOAD_LEFT)
                       && (r_lcnt < RC_W'(MAX_LEN));
    assign out_free  = !o_valid || !i_stall;

    // sequence stores, read at the current column and row
    lalg_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(SAW)) u_top_mem (
        .i_clk  (i_clk),
        .i_we   (load_top),
        .i_waddr(r_tcnt[SAW-1:0]),
        .i_wdata(i_symbol),
        .i_raddr(c_m1[SAW-1:0]),
        .o_rdata(top_rd)
    );

    lalg_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(SAW)) u_left_mem (
        .i_clk  (i_clk),
        .i_we   (load_left),
        .i_waddr(r_lcnt[SAW-1:0]),
        .i_wdata(i_symbol),
        .i_raddr(r_m1[SAW-1:0]),
        .o_rdata(left_rd)
    );

    // score read address by step
    always_comb begin
        case (r_state)
            S_FRD:   score_raddr = f_addr(r_m1, r_c);
            S_THD:   score_raddr = f_addr(r_m1, c_m1);
            S_TDD:   score_raddr = f_addr(r_r, c_m1);
            default: score_raddr = f_addr(r_r, r_c);
        endcase
    end

    assign score_we = (r_state == S_FCMP);

    lalg_ram #(.WIDTH(SW), .DEPTH(MAX_LEN * MAX_LEN), .AW(MAW)) u_score_mem (
        .i_clk  (i_clk),
        .i_we   (score_we),
        .i_waddr(f_addr(r_r, r_c)),
        .i_wdata(pe_val),
        .i_raddr(score_raddr),
        .o_rdata(score_rd)
    );

    // border cells read as zero
    assign up_now   = (r_r == RC_W'(1)) ? '0 : score_rd;
    assign left_now = (r_c == RC_W'(1)) ? '0 : score_rd;
    assign pe_left  = (r_state == S_FCMP) ? r_left : left_now;
    assign pe_up    = (r_state == S_FCMP) ? up_now : '0;
    assign here_ext = $signed({2'b00, r_here});

    lalg_pe #(.SW(SW)) u_pe (
        .i_diag    (r_diag),
        .i_up      (pe_up),
        .i_left    (pe_left),
        .i_sym_eq  (top_rd == left_rd),
        .i_match   (r_match),
        .i_mismatch(r_mismatch),
        .i_gap     (r_gap),
        .o_diag_sum(pe_dsum),
        .o_left_sum(pe_lsum),
        .o_val     (pe_val)
    );

    // saturated summary fields
    assign best_ext = (SW + 9)'(r_best);
    assign br_ext   = (RC_W + 6)'(r_br);
    assign bc_ext   = (RC_W + 6)'(r_bc);

    assign emit = ((r_state == S_TPUT) && r_pend_v && out_free)
                  || ((r_state == S_TFIN) && out_free);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= lalg_pkg::MATCH_RST;
            r_mismatch <= lalg_pkg::MISMATCH_RST;
            r_gap      <= lalg_pkg::GAP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lalg_pkg::REG_MATCH:    r_match    <= i_cfg_data[3:0];
                lalg_pkg::REG_MISMATCH: r_mismatch <= i_cfg_data;
                lalg_pkg::REG_GAP:      r_gap      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_pair_valid <= r_pend_v;
            o_top_out    <= r_pend_v ? r_pend_top : 8'd0;
            o_left_out   <= r_pend_v ? r_pend_left : 8'd0;
            o_last       <= (r_state == S_TFIN);
            o_best_score <= (best_ext > (SW + 9)'(511)) ? 9'd511 : best_ext[8:0];
            o_end_row    <= (br_ext > (RC_W + 6)'(63)) ? 6'd63 : br_ext[5:0];
            o_end_col    <= (bc_ext > (RC_W + 6)'(63)) ? 6'd63 : bc_ext[5:0];
        end
    end

    // sequencer: fill, then traceback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tcnt   <= '0;
            r_lcnt   <= '0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (load_top) r_tcnt <= r_tcnt + 1'b1;
                    if (load_left) r_lcnt <= r_lcnt + 1'b1;
                    if (i_valid && (i_action == lalg_pkg::ACT_RUN)) begin
                        r_best   <= '0;
                        r_br     <= '0;
                        r_bc     <= '0;
                        r_r      <= RC_W'(1);
                        r_c      <= RC_W'(1);
                        r_diag   <= '0;
                        r_left   <= '0;
                        r_pend_v <= 1'b0;
                        r_n      <= '0;
                        if ((r_tcnt == '0) || (r_lcnt == '0)) r_state <= S_TFIN;
                        else r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    if (pe_val > r_best) begin
                        r_best <= pe_val;
                        r_br   <= r_r;
                        r_bc   <= r_c;
                    end
                    if (r_c == r_tcnt) begin
                        r_c    <= RC_W'(1);
                        r_diag <= '0;
                        r_left <= '0;
                        if (r_r == r_lcnt) r_state <= S_FDONE;
                        else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_FRD;
                        end
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_diag  <= up_now;
                        r_left  <= pe_val;
                        r_state <= S_FRD;
                    end
                end
                S_FDONE: begin
                    r_r     <= r_br;
                    r_c     <= r_bc;
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    if ((r_r == '0) || (r_c == '0) || (r_n == NW'(lalg_pkg::RESULT_CAP)))
                        r_state <= S_TFIN;
                    else r_state <= S_THD;
                end
                S_THD: begin
                    r_here <= score_rd;
                    if (score_rd == '0) r_state <= S_TFIN;
                    else r_state <= S_TDD;
                end
                S_TDD: begin
                    r_diag  <= ((r_r == RC_W'(1)) || (r_c == RC_W'(1))) ? '0 : score_rd;
                    r_state <= S_TLD;
                end
                S_TLD: begin
                    if (here_ext == pe_dsum) begin
                        r_nxt_top  <= top_rd;
                        r_nxt_left <= left_rd;
                        r_r        <= r_m1;
                        r_c        <= c_m1;
                    end else if (here_ext == pe_lsum) begin
                        r_nxt_top  <= top_rd;
                        r_nxt_left <= lalg_pkg::GAP_SYM;
                        r_c        <= c_m1;
                    end else begin
                        r_nxt_top  <= lalg_pkg::GAP_SYM;
                        r_nxt_left <= left_rd;
                        r_r        <= r_m1;
                    end
                    r_state <= S_TPUT;
                end
                S_TPUT: begin
                    if (!r_pend_v || out_free) begin
                        r_pend_v    <= 1'b1;
                        r_pend_top  <= r_nxt_top;
                        r_pend_left <= r_nxt_left;
                        r_n         <= r_n + 1'b1;
                        r_state     <= S_TCHK;
                    end
                end
                S_TFIN: begin
                    if (out_free) begin
                        r_pend_v <= 1'b0;
                        r_tcnt   <= '0;
                        r_lcnt   <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(lalg_pkg::RESULT_CAP))
        else $error("traceback pair count over cap");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pair_valid |-> o_last)
        else $error("empty result not marked last");

    a_fill_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCMP) |-> (r_c != '0) && (r_c <= r_tcnt) && (r_r <= r_lcnt))
        else $error("fill position outside matrix");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tcnt <= RC_W'(MAX_LEN)) && (r_lcnt <= RC_W'(MAX_LEN)))
        else $error("sequence length over capacity");

endmodule
`default_nettype wire
